// ----- hdl/isr_pkg.sv -----
package isr_pkg;

  // fixed field widths
  localparam int unsigned SYM_W = 8;
  localparam int unsigned CFG_W = 64;
  localparam int unsigned LEN_W = 5;
  localparam int unsigned IDX_W = 2;
  localparam int unsigned DIG_W = 4;
  localparam int unsigned SYMS_W = 2 * CFG_W;

  // quotient bits resolved per divider cycle
  localparam int unsigned STEP = 8;

  // special symbols
  localparam logic [SYM_W-1:0] MINUS_SYM = 8'h2D;
  localparam logic [SYM_W-1:0] PLUS_SYM  = 8'h2B;
  localparam logic [SYM_W-1:0] NUL_SYM   = 8'h00;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_SYMBOLS_LOW  = 2'd0,
    REG_SYMBOLS_HIGH = 2'd1,
    REG_BASE_LENGTH  = 2'd2
  } cfg_reg_e;

  // back end sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_SIGN = 5'b00100,
    S_RD   = 5'b01000,
    S_OUT  = 5'b10000
  } back_state_e;

  // alphabet as seen by the back end
  typedef struct packed {
    logic [SYMS_W-1:0] syms;
    logic [LEN_W-1:0]  len;
  } alpha_t;

  // symbol byte for a digit value
  function automatic logic [SYM_W-1:0] sym_at(input logic [SYMS_W-1:0] syms,
                                              input logic [DIG_W-1:0] d);
    sym_at = syms[d * SYM_W +: SYM_W];
  endfunction

endpackage

// ----- hdl/isr_front.sv -----
module isr_front #(
  parameter int unsigned MAX_SYMBOLS = 16,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [isr_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [isr_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  input  logic                         full_i,
  output logic                         push_o,
  output logic [VALUE_BITS:0]          push_data_o,
  output isr_pkg::alpha_t              alpha_o
);
  import isr_pkg::*;

  logic [CFG_W-1:0]      sym_lo_q, sym_hi_q;
  logic [LEN_W-1:0]      len_q;
  logic [SYMS_W-1:0]     syms;
  logic                  alpha_ok;
  logic [SYM_W-1:0]      s;
  logic [VALUE_BITS-1:0] v_u;
  logic                  neg;
  logic [VALUE_BITS-1:0] mag;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_lo_q <= '0;
      sym_hi_q <= '0;
      len_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SYMBOLS_LOW:  sym_lo_q <= cfg_data_i;
        REG_SYMBOLS_HIGH: sym_hi_q <= cfg_data_i;
        REG_BASE_LENGTH:  len_q    <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign syms = {sym_hi_q, sym_lo_q};

  // alphabet check: length range, forbidden bytes, duplicates
  always_comb begin
    s = NUL_SYM;
    alpha_ok = (len_q >= LEN_W'(2)) && (len_q <= LEN_W'(MAX_SYMBOLS));
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (LEN_W'(i) < len_q) begin
        s = sym_at(syms, DIG_W'(i));
        if (s == NUL_SYM || s == PLUS_SYM || s == MINUS_SYM) alpha_ok = 1'b0;
        for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
          if (LEN_W'(j) < len_q && sym_at(syms, DIG_W'(j)) == s) alpha_ok = 1'b0;
        end
      end
    end
  end

  // classify: sign and magnitude
  assign v_u = $unsigned(value_i);
  assign neg = v_u[VALUE_BITS-1];
  assign mag = neg ? (~v_u + 1'b1) : v_u;

  // words are dropped when the alphabet is invalid
  assign in_stall_o  = full_i;
  assign push_o      = in_valid_i && !full_i && alpha_ok;
  assign push_data_o = {neg, mag};

  assign alpha_o.syms = syms;
  assign alpha_o.len  = len_q;

endmodule

// ----- hdl/isr_fifo.sv -----
module isr_fifo #(
  parameter int unsigned WIDTH = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned DEPTH = 2;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;

  assign full_o  = (cnt_q == 2'(DEPTH));
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue popped while empty");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(DEPTH)) else $error("queue fill level out of range");

endmodule

// ----- hdl/isr_back.sv -----
module isr_back #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        entry_valid_i,
  input  logic [VALUE_BITS:0]         entry_data_i,
  output logic                        pop_o,
  input  isr_pkg::alpha_t             alpha_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [isr_pkg::SYM_W-1:0]   symbol_o,
  output logic                        last_o
);
  import isr_pkg::*;

  localparam int unsigned DIV_W  = ((VALUE_BITS + STEP - 1) / STEP) * STEP;
  localparam int unsigned ROUNDS = DIV_W / STEP;
  localparam int unsigned RND_W  = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int unsigned AW     = $clog2(VALUE_BITS);
  localparam int unsigned CNT_W  = $clog2(VALUE_BITS + 1);

  back_state_e      state_q, state_d;
  logic [DIV_W-1:0] mag_q, mag_d;
  logic [DIG_W-1:0] rem_q, rem_d, rem_nx;
  logic [RND_W-1:0] round_q, round_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_m1;
  logic             neg_q, neg_d;
  logic [STEP-1:0]  quo;
  logic [DIG_W:0]   t;
  logic             dig_we;
  logic [DIG_W-1:0] dig_mem [VALUE_BITS];
  logic [DIG_W-1:0] dig_rd_q;
  logic [AW-1:0]    rd_addr;
  logic             out_valid_q, out_valid_d;
  logic [SYM_W-1:0] symbol_q, symbol_d;
  logic             last_q, last_d;
  logic             slot_free, load;

  // divider slice: STEP restoring steps on the top bits of the magnitude
  always_comb begin
    quo    = '0;
    rem_nx = rem_q;
    t      = '0;
    for (int k = 0; k < STEP; k++) begin
      t = {rem_nx, mag_q[DIV_W-1-k]};
      if (t >= alpha_i.len) begin
        quo[STEP-1-k] = 1'b1;
        rem_nx = DIG_W'(t - alpha_i.len);
      end else begin
        rem_nx = t[DIG_W-1:0];
      end
    end
  end

  // digit buffer, registered read
  assign cnt_m1  = cnt_q - CNT_W'(1);
  assign rd_addr = cnt_m1[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (dig_we) dig_mem[cnt_q[AW-1:0]] <= rem_nx;
    dig_rd_q <= dig_mem[rd_addr];
  end

  assign slot_free = !out_valid_q || !out_stall_i;

  // sequencer
  always_comb begin
    state_d  = state_q;
    mag_d    = mag_q;
    rem_d    = rem_q;
    round_d  = round_q;
    cnt_d    = cnt_q;
    neg_d    = neg_q;
    symbol_d = symbol_q;
    last_d   = last_q;
    pop_o    = 1'b0;
    dig_we   = 1'b0;
    load     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (entry_valid_i) begin
          pop_o   = 1'b1;
          mag_d   = DIV_W'(entry_data_i[VALUE_BITS-1:0]);
          neg_d   = entry_data_i[VALUE_BITS];
          cnt_d   = '0;
          round_d = '0;
          rem_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        mag_d   = (mag_q << STEP) | DIV_W'(quo);
        rem_d   = rem_nx;
        round_d = round_q + RND_W'(1);
        if (round_q == RND_W'(ROUNDS - 1)) begin
          dig_we  = 1'b1;
          cnt_d   = cnt_q + CNT_W'(1);
          rem_d   = '0;
          round_d = '0;
          if (mag_d == '0) state_d = neg_q ? S_SIGN : S_RD;
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          load     = 1'b1;
          symbol_d = MINUS_SYM;
          last_d   = 1'b0;
          state_d  = S_RD;
        end
      end
      S_RD: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          load     = 1'b1;
          symbol_d = sym_at(alpha_i.syms, dig_rd_q);
          last_d   = (cnt_q == CNT_W'(1));
          cnt_d    = cnt_m1;
          state_d  = (cnt_q == CNT_W'(1)) ? S_IDLE : S_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output register
  assign out_valid_d = load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      round_q     <= '0;
      rem_q       <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      round_q     <= round_d;
      rem_q       <= rem_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    symbol_q <= symbol_d;
    last_q   <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign symbol_o    = symbol_q;
  assign last_o      = last_q;

  a_buf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (cnt_q < CNT_W'(VALUE_BITS)))
    else $error("digit buffer overrun");
  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && last_d) |=> (state_q == S_IDLE))
    else $error("run flagged last but sequencer still busy");

endmodule

// ----- hdl/signed_integer_to_radix_symbols.sv -----
// channel   direction  handshake               payload
// in        input      in_valid_i / in_stall_o   value_i
// out       output     out_valid_o / out_stall_i symbol_o, last_o
// cfg       input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// the back end takes a word, divides it by the base one digit at a time (8 quotient
// bits per cycle), emits a sign for a negative value and then each digit, most
// significant first, with a registered digit buffer read (S_RD) before each output (S_OUT)
// a 2-entry queue lets the input side take words while the back end works
// reset is asynchronous active low; no clearing pass is needed
// words taken while the alphabet is invalid produce no output
module signed_integer_to_radix_symbols #(
  parameter int unsigned MAX_SYMBOLS = 16,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [isr_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [isr_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [isr_pkg::SYM_W-1:0]    symbol_o,
  output logic                         last_o
);
  import isr_pkg::*;

  logic                  full;
  logic                  push;
  logic [VALUE_BITS:0]   push_data;
  logic                  pop;
  logic                  entry_valid;
  logic [VALUE_BITS:0]   entry_data;
  alpha_t                alpha;

  // config, alphabet check and classify
  isr_front #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data),
    .alpha_o     (alpha)
  );

  // queue between front and back
  isr_fifo #(
    .WIDTH (VALUE_BITS + 1)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (entry_valid),
    .data_o      (entry_data)
  );

  // digit extraction and symbol emission
  isr_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (entry_valid),
    .entry_data_i  (entry_data),
    .pop_o         (pop),
    .alpha_i       (alpha),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .symbol_o      (symbol_o),
    .last_o        (last_o)
  );

endmodule
